// File: rtl/core/cnms_pkg.sv
// Shared types, constants and helper functions for the cron next-match search.
// No dependencies; imported by every module of the block.
package cnms_pkg;

    localparam int YEAR_W     = 12;
    localparam int RULE_W     = 18;
    localparam int YRULE_W    = 34;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 34;
    localparam int WMASK_W    = 7;
    localparam int YSTEP_W    = 10;

    localparam int YEAR_LIMIT_DEF = 2040;
    localparam int YEAR_BASE_DEF  = 1970;

    localparam logic [RULE_W-1:0]  MINUTE_RULE_RST = 18'd3776;
    localparam logic [RULE_W-1:0]  HOUR_RULE_RST   = 18'd5568;
    localparam logic [RULE_W-1:0]  DAY_RULE_RST    = 18'd6081;
    localparam logic [RULE_W-1:0]  MONTH_RULE_RST  = 18'd4865;
    localparam logic [YRULE_W-1:0] YEAR_RULE_RST   = 34'd4329830322;
    localparam logic [WMASK_W-1:0] WMASK_RST       = 7'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MINUTE = 3'd0,
        CFG_HOUR   = 3'd1,
        CFG_DAY    = 3'd2,
        CFG_MONTH  = 3'd3,
        CFG_YEAR   = 3'd4,
        CFG_WMASK  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [11:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [4:0]  start_hour;
        logic [5:0]  start_minute;
    } req_t;

    typedef struct packed {
        logic [11:0] next_year;
        logic [3:0]  next_month;
        logic [4:0]  next_day;
        logic [4:0]  next_hour;
        logic [5:0]  next_minute;
        logic        no_match;
    } rsp_t;

    typedef enum logic [4:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_PRE_H,
        CMD_PRE_MI,
        CMD_YEAR_NEXT,
        CMD_YEAR_ENTER,
        CMD_MONTH_NEXT,
        CMD_WD1,
        CMD_WD2,
        CMD_WD3,
        CMD_DAY_NEXT,
        CMD_DAY_ENTER,
        CMD_HOUR_NEXT,
        CMD_HOUR_ENTER,
        CMD_MIN_NEXT,
        CMD_EMIT_HIT,
        CMD_EMIT_MISS
    } cmd_t;

    typedef struct packed {
        logic mod_done;
        logic y_end;
        logic y_ok;
        logic m_ok;
        logic m_last;
        logic d_ok;
        logic d_last;
        logic hr_rule_ok;
        logic h_ok;
        logic h_last;
        logic min_rule_ok;
        logic mi_ok;
        logic mi_last;
    } status_t;

    function automatic logic [5:0] step_eff6(input logic [5:0] s);
        return (s == 6'd0) ? 6'd1 : s;
    endfunction

    function automatic logic [YSTEP_W-1:0] step_eff10(input logic [YSTEP_W-1:0] s);
        return (s == '0) ? YSTEP_W'(1) : s;
    endfunction

    function automatic logic [5:0] res_inc6(input logic [5:0] r, input logic [5:0] st);
        return ((r + 6'd1) == st) ? 6'd0 : r + 6'd1;
    endfunction

    function automatic logic [YSTEP_W-1:0] res_inc10(input logic [YSTEP_W-1:0] r,
                                                     input logic [YSTEP_W-1:0] st);
        return ((r + YSTEP_W'(1)) == st) ? '0 : r + YSTEP_W'(1);
    endfunction

    // residue of the value one
    function automatic logic [5:0] res_one6(input logic [5:0] st);
        return (st == 6'd1) ? 6'd0 : 6'd1;
    endfunction

    function automatic logic rule_ok6(input logic [5:0] v, input logic [RULE_W-1:0] rule,
                                      input logic [5:0] r);
        return (v >= rule[5:0]) && (v <= rule[11:6]) && (r == 6'd0);
    endfunction

    function automatic logic [2:0] wd_offset(input logic [3:0] m);
        logic [2:0] o;
        unique case (m)
            4'd2:    o = 3'd3;
            4'd3:    o = 3'd2;
            4'd4:    o = 3'd5;
            4'd6:    o = 3'd3;
            4'd7:    o = 3'd5;
            4'd8:    o = 3'd1;
            4'd9:    o = 3'd4;
            4'd10:   o = 3'd6;
            4'd11:   o = 3'd2;
            4'd12:   o = 3'd4;
            default: o = 3'd0;
        endcase
        return o;
    endfunction

endpackage

// File: rtl/core/cron_next_match_search.sv
// Cron next-match search: given a start moment, returns the first later minute on which
// the minute, hour, day, month, year and weekday rules all hold, or a no-match flag.
// One search at a time. A search first sets up: it waits on the bit-serial year remainder
// unit, then scans up to 24 hours and 60 minutes for any allowed value. Then the controller
// walks the candidate minutes, hours, days, months and years, with a weekday set-up for
// each month entered. A new request is taken once the previous result is in the output
// register, even while that result still waits to be taken.
// Depends on cnms_pkg, cnms_ctrl, cnms_datapath and cnms_ymod.
module cron_next_match_search
    import cnms_pkg::*;
#(
    parameter int YEAR_LIMIT = YEAR_LIMIT_DEF,
    parameter int YEAR_BASE  = YEAR_BASE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp
);

    cmd_t    cmd;
    status_t st;

    cnms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .st        (st),
        .cmd       (cmd)
    );

    cnms_datapath #(
        .YEAR_LIMIT (YEAR_LIMIT),
        .YEAR_BASE  (YEAR_BASE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .st        (st),
        .rsp       (rsp)
    );

endmodule

// File: rtl/core/cnms_ymod.sv
// Bit-serial remainder unit: year modulo year step, one dividend bit a cycle.
// Depends on cnms_pkg.
module cnms_ymod
    import cnms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [YEAR_W-1:0]  dividend,
    input  logic [YSTEP_W-1:0] divisor,
    output logic               done,
    output logic [YSTEP_W-1:0] rem
);

    localparam int CNT_W = $clog2(YEAR_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [YEAR_W-1:0]  dvd_reg, dvd_next;
    logic [YSTEP_W-1:0] div_reg, div_next;
    logic [YSTEP_W-1:0] rem_reg, rem_next;
    logic [YSTEP_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[YEAR_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                trial = trial - {1'b0, div_reg};
            rem_next = trial[YSTEP_W-1:0];
            dvd_next = {dvd_reg[YEAR_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(YEAR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/core/cnms_datapath.sv
// Search datapath: rule registers, calendar counters, step residues, weekday.
// Depends on cnms_pkg and cnms_ymod; driven by cnms_ctrl commands.
module cnms_datapath
    import cnms_pkg::*;
#(
    parameter int YEAR_LIMIT = YEAR_LIMIT_DEF,
    parameter int YEAR_BASE  = YEAR_BASE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  req_t                  req,
    output status_t               st,
    output rsp_t                  rsp
);

    logic [RULE_W-1:0]  minute_rule_reg, hour_rule_reg, day_rule_reg, month_rule_reg;
    logic [YRULE_W-1:0] year_rule_reg;
    logic [WMASK_W-1:0] wmask_reg;

    req_t               req_reg;
    rsp_t               rsp_reg;
    logic [YEAR_W-1:0]  y_reg;
    logic [3:0]         m_reg;
    logic [4:0]         d_reg;
    logic [4:0]         h_reg;
    logic [5:0]         mi_reg;
    logic [YSTEP_W-1:0] resy_reg;
    logic [5:0]         resm_reg, resd_reg, resh_reg, resmi_reg;
    logic [5:0]         q100yy_reg, q100y_reg;
    logic [13:0]        s_reg;
    logic               leap_reg;
    logic [2:0]         wd_reg;

    logic [5:0]         mst, dst, hst, mist;
    logic [YSTEP_W-1:0] yst;
    logic [YEAR_W-1:0]  y_start, yy;
    logic [24:0]        prod_yy, prod_y;
    logic [27:0]        prod7;
    logic [13:0]        q7;
    logic [13:0]        r7;
    logic [YEAR_W-1:0]  y100;
    logic [4:0]         mdays;
    logic               ty, tm, td, th;
    logic               mod_done;
    logic [YSTEP_W-1:0] mod_rem;

    assign mst  = step_eff6(month_rule_reg[17:12]);
    assign dst  = step_eff6(day_rule_reg[17:12]);
    assign hst  = step_eff6(hour_rule_reg[17:12]);
    assign mist = step_eff6(minute_rule_reg[17:12]);
    assign yst  = step_eff10(year_rule_reg[33:24]);

    assign y_start = (req.start_year > YEAR_W'(YEAR_BASE)) ? req.start_year
                                                            : YEAR_W'(YEAR_BASE);

    cnms_ymod u_ymod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd == CMD_LOAD),
        .dividend (y_start),
        .divisor  (yst),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // weekday: year before March counts as the previous one
    assign yy      = (m_reg < 4'd3) ? y_reg - YEAR_W'(1) : y_reg;
    assign prod_yy = {13'd0, yy} * 25'd5243;
    assign prod_y  = {13'd0, y_reg} * 25'd5243;
    assign prod7   = {14'd0, s_reg} * 28'd9363;
    assign q7      = prod7[29-2:16] & 14'h0FFF;
    assign r7      = s_reg - ((q7 << 3) - q7);
    assign y100    = YEAR_W'({6'd0, q100y_reg} * YEAR_W'(100));

    always_comb
    begin
        if (m_reg == 4'd2)
            mdays = leap_reg ? 5'd29 : 5'd28;
        else if (m_reg == 4'd4 || m_reg == 4'd6 || m_reg == 4'd9 || m_reg == 4'd11)
            mdays = 5'd30;
        else
            mdays = 5'd31;
    end

    assign ty = (y_reg == req_reg.start_year);
    assign tm = ty && (m_reg == req_reg.start_month);
    assign td = tm && (d_reg == req_reg.start_day);
    assign th = td && (h_reg == req_reg.start_hour);

    always_comb
    begin
        st.mod_done    = mod_done;
        st.y_end       = (y_reg >= YEAR_W'(YEAR_LIMIT));
        st.y_ok        = (y_reg >= year_rule_reg[11:0]) && (y_reg <= year_rule_reg[23:12])
                         && (resy_reg == '0);
        st.m_ok        = rule_ok6({2'b0, m_reg}, month_rule_reg, resm_reg)
                         && (!ty || m_reg >= req_reg.start_month);
        st.m_last      = (m_reg == 4'd12);
        st.d_ok        = (d_reg <= mdays) && rule_ok6({1'b0, d_reg}, day_rule_reg, resd_reg)
                         && wmask_reg[wd_reg] && (!tm || d_reg >= req_reg.start_day);
        st.d_last      = (d_reg == 5'd31);
        st.hr_rule_ok  = rule_ok6({1'b0, h_reg}, hour_rule_reg, resh_reg);
        st.h_ok        = st.hr_rule_ok && (!td || h_reg >= req_reg.start_hour);
        st.h_last      = (h_reg == 5'd23);
        st.min_rule_ok = rule_ok6(mi_reg, minute_rule_reg, resmi_reg);
        st.mi_ok       = st.min_rule_ok && (!th || mi_reg > req_reg.start_minute);
        st.mi_last     = (mi_reg == 6'd59);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minute_rule_reg <= MINUTE_RULE_RST;
            hour_rule_reg   <= HOUR_RULE_RST;
            day_rule_reg    <= DAY_RULE_RST;
            month_rule_reg  <= MONTH_RULE_RST;
            year_rule_reg   <= YEAR_RULE_RST;
            wmask_reg       <= WMASK_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MINUTE)
                minute_rule_reg <= cfg_data[RULE_W-1:0];
            if (cfg_index == CFG_HOUR)
                hour_rule_reg <= cfg_data[RULE_W-1:0];
            if (cfg_index == CFG_DAY)
                day_rule_reg <= cfg_data[RULE_W-1:0];
            if (cfg_index == CFG_MONTH)
                month_rule_reg <= cfg_data[RULE_W-1:0];
            if (cfg_index == CFG_YEAR)
                year_rule_reg <= cfg_data[YRULE_W-1:0];
            if (cfg_index == CFG_WMASK)
                wmask_reg <= cfg_data[WMASK_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mod_done)
            resy_reg <= mod_rem;
        unique case (cmd)
            CMD_LOAD:
            begin
                req_reg   <= req;
                y_reg     <= y_start;
                h_reg     <= 5'd0;
                resh_reg  <= 6'd0;
                mi_reg    <= 6'd0;
                resmi_reg <= 6'd0;
            end
            CMD_PRE_H, CMD_HOUR_NEXT:
            begin
                h_reg    <= h_reg + 5'd1;
                resh_reg <= res_inc6(resh_reg, hst);
            end
            CMD_PRE_MI, CMD_MIN_NEXT:
            begin
                mi_reg    <= mi_reg + 6'd1;
                resmi_reg <= res_inc6(resmi_reg, mist);
            end
            CMD_YEAR_NEXT:
            begin
                y_reg    <= y_reg + YEAR_W'(1);
                resy_reg <= res_inc10(resy_reg, yst);
            end
            CMD_YEAR_ENTER:
            begin
                m_reg    <= 4'd1;
                resm_reg <= res_one6(mst);
            end
            CMD_MONTH_NEXT:
            begin
                m_reg    <= m_reg + 4'd1;
                resm_reg <= res_inc6(resm_reg, mst);
            end
            CMD_WD1:
            begin
                q100yy_reg <= prod_yy[24:19];
                q100y_reg  <= prod_y[24:19];
            end
            CMD_WD2:
            begin
                s_reg    <= 14'(yy) + 14'(yy >> 2) - 14'(q100yy_reg) + 14'(q100yy_reg >> 2)
                            + 14'(wd_offset(m_reg));
                leap_reg <= (y_reg[1:0] == 2'd0) && ((y_reg != y100) || (q100y_reg[1:0] == 2'd0));
            end
            CMD_WD3:
            begin
                wd_reg   <= (r7[2:0] == 3'd6) ? 3'd0 : r7[2:0] + 3'd1;
                d_reg    <= 5'd1;
                resd_reg <= res_one6(dst);
            end
            CMD_DAY_NEXT:
            begin
                d_reg    <= d_reg + 5'd1;
                resd_reg <= res_inc6(resd_reg, dst);
                wd_reg   <= (wd_reg == 3'd6) ? 3'd0 : wd_reg + 3'd1;
            end
            CMD_DAY_ENTER:
            begin
                h_reg    <= 5'd0;
                resh_reg <= 6'd0;
            end
            CMD_HOUR_ENTER:
            begin
                mi_reg    <= 6'd0;
                resmi_reg <= 6'd0;
            end
            CMD_EMIT_HIT:
            begin
                rsp_reg.next_year   <= y_reg;
                rsp_reg.next_month  <= m_reg;
                rsp_reg.next_day    <= d_reg;
                rsp_reg.next_hour   <= h_reg;
                rsp_reg.next_minute <= mi_reg;
                rsp_reg.no_match    <= 1'b0;
            end
            CMD_EMIT_MISS:
            begin
                rsp_reg.next_year   <= '0;
                rsp_reg.next_month  <= '0;
                rsp_reg.next_day    <= '0;
                rsp_reg.next_hour   <= '0;
                rsp_reg.next_minute <= '0;
                rsp_reg.no_match    <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp = rsp_reg;

endmodule

// File: rtl/core/cnms_ctrl.sv
// Search controller: nested year/month/day/hour/minute walk and output handshake.
// Depends on cnms_pkg; commands cnms_datapath.
module cnms_ctrl
    import cnms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_YMOD,
        S_PRE_H,
        S_PRE_MI,
        S_YEAR,
        S_MONTH,
        S_WD2,
        S_WD3,
        S_DAY,
        S_HOUR,
        S_MIN,
        S_HIT,
        S_MISS
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    cmd_t   adv_cmd;
    state_t adv_state;
    logic   out_free;

    assign out_free = !out_valid_reg || !rsp_stall;

    // move on to the next day, carrying into month and year
    always_comb
    begin
        if (!st.d_last)
        begin
            adv_cmd   = CMD_DAY_NEXT;
            adv_state = S_DAY;
        end
        else if (!st.m_last)
        begin
            adv_cmd   = CMD_MONTH_NEXT;
            adv_state = S_MONTH;
        end
        else
        begin
            adv_cmd   = CMD_YEAR_NEXT;
            adv_state = S_YEAR;
        end
    end

    always_comb
    begin
        cmd            = CMD_IDLE;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
                if (req_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_YMOD;
                end
            S_YMOD:
                if (st.mod_done)
                    state_next = S_PRE_H;
            S_PRE_H:
            begin
                cmd = CMD_PRE_H;
                if (st.hr_rule_ok)
                    state_next = S_PRE_MI;
                else if (st.h_last)
                    state_next = S_MISS;
            end
            S_PRE_MI:
            begin
                cmd = CMD_PRE_MI;
                if (st.min_rule_ok)
                    state_next = S_YEAR;
                else if (st.mi_last)
                    state_next = S_MISS;
            end
            S_YEAR:
                priority if (st.y_end)
                    state_next = S_MISS;
                else if (st.y_ok)
                begin
                    cmd        = CMD_YEAR_ENTER;
                    state_next = S_MONTH;
                end
                else
                    cmd = CMD_YEAR_NEXT;
            S_MONTH:
                priority if (st.m_ok)
                begin
                    cmd        = CMD_WD1;
                    state_next = S_WD2;
                end
                else if (st.m_last)
                begin
                    cmd        = CMD_YEAR_NEXT;
                    state_next = S_YEAR;
                end
                else
                    cmd = CMD_MONTH_NEXT;
            S_WD2:
            begin
                cmd        = CMD_WD2;
                state_next = S_WD3;
            end
            S_WD3:
            begin
                cmd        = CMD_WD3;
                state_next = S_DAY;
            end
            S_DAY:
                if (st.d_ok)
                begin
                    cmd        = CMD_DAY_ENTER;
                    state_next = S_HOUR;
                end
                else
                begin
                    cmd        = adv_cmd;
                    state_next = adv_state;
                end
            S_HOUR:
                priority if (st.h_ok)
                begin
                    cmd        = CMD_HOUR_ENTER;
                    state_next = S_MIN;
                end
                else if (st.h_last)
                begin
                    cmd        = adv_cmd;
                    state_next = adv_state;
                end
                else
                    cmd = CMD_HOUR_NEXT;
            S_MIN:
                priority if (st.mi_ok)
                    state_next = S_HIT;
                else if (st.mi_last)
                begin
                    if (st.h_last)
                    begin
                        cmd        = adv_cmd;
                        state_next = adv_state;
                    end
                    else
                    begin
                        cmd        = CMD_HOUR_NEXT;
                        state_next = S_HOUR;
                    end
                end
                else
                    cmd = CMD_MIN_NEXT;
            S_HIT:
                if (out_free)
                begin
                    cmd            = CMD_EMIT_HIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            S_MISS:
                if (out_free)
                begin
                    cmd            = CMD_EMIT_MISS;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

// File: tb/tb_cron_next_match_search.sv
// Testbench for cron_next_match_search: directed table then randomised starts under several
// rule sets, every transfer checked field by field against the table or a bench search model.
// Depends on cnms_pkg and the cron_next_match_search RTL.
module tb_cron_next_match_search
    import cnms_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  req_valid;
    logic                  req_stall;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_t                  rsp;

    cron_next_match_search dut (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // local copy of the rule registers
    logic [RULE_W-1:0]  r_min, r_hour, r_day, r_mon;
    logic [YRULE_W-1:0] r_year;
    logic [WMASK_W-1:0] r_wmask;

    rsp_t pending_q[$];
    int   errors;
    bit   quiet;
    bit   press_go;
    int   hold_cnt;

    function automatic bit in_rule(int unsigned v, int unsigned lo, int unsigned hi,
                                   int unsigned st);
        if (st == 0)
            st = 1;
        return v >= lo && v <= hi && (v % st) == 0;
    endfunction

    function automatic bit rule6(int unsigned v, logic [RULE_W-1:0] r);
        return in_rule(v, r[5:0], r[11:6], r[17:12]);
    endfunction

    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in(int unsigned y, int unsigned m);
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic int unsigned day_of_week(int unsigned y, int unsigned m, int unsigned d);
        int unsigned offs[12];
        int unsigned yy;
        offs = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
        yy = (m < 3) ? y - 1 : y;
        return (yy + yy / 4 - yy / 100 + yy / 400 + offs[m - 1] + d) % 7;
    endfunction

    function automatic rsp_t next_match(req_t s);
        rsp_t o;
        bit any_h, any_mi, ty, tm, td, th;
        int unsigned y, m, d, h, mi;
        o = '0;
        o.no_match = 1'b1;
        any_h = 0;
        any_mi = 0;
        for (h = 0; h <= 23; h++)
            if (rule6(h, r_hour))
                any_h = 1;
        for (mi = 0; mi <= 59; mi++)
            if (rule6(mi, r_min))
                any_mi = 1;
        if (!any_h || !any_mi)
            return o;
        for (y = (s.start_year > YEAR_BASE_DEF) ? s.start_year : YEAR_BASE_DEF;
             y < YEAR_LIMIT_DEF; y++)
        begin
            ty = (y == s.start_year);
            if (!in_rule(y, r_year[11:0], r_year[23:12], r_year[33:24]))
                continue;
            for (m = ty ? s.start_month : 1; m <= 12; m++)
            begin
                tm = ty && m == s.start_month;
                if (m == 0 || !rule6(m, r_mon))
                    continue;
                for (d = tm ? s.start_day : 1; d <= 31; d++)
                begin
                    td = tm && d == s.start_day;
                    if (d == 0 || d > days_in(y, m) || !rule6(d, r_day))
                        continue;
                    if (!r_wmask[day_of_week(y, m, d)])
                        continue;
                    for (h = td ? s.start_hour : 0; h <= 23; h++)
                    begin
                        th = td && h == s.start_hour;
                        if (!rule6(h, r_hour))
                            continue;
                        for (mi = th ? s.start_minute + 1 : 0; mi <= 59; mi++)
                        begin
                            if (rule6(mi, r_min))
                            begin
                                o.next_year   = 12'(y);
                                o.next_month  = 4'(m);
                                o.next_day    = 5'(d);
                                o.next_hour   = 5'(h);
                                o.next_minute = 6'(mi);
                                o.no_match    = 1'b0;
                                return o;
                            end
                        end
                    end
                end
            end
        end
        return o;
    endfunction

    function automatic logic [RULE_W-1:0] pack6(int lo, int hi, int st);
        return {st[5:0], hi[5:0], lo[5:0]};
    endfunction

    function automatic logic [YRULE_W-1:0] pack_year(int lo, int hi, int st);
        return {st[9:0], hi[11:0], lo[11:0]};
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_MINUTE: r_min   = val[RULE_W-1:0];
            CFG_HOUR:   r_hour  = val[RULE_W-1:0];
            CFG_DAY:    r_day   = val[RULE_W-1:0];
            CFG_MONTH:  r_mon   = val[RULE_W-1:0];
            CFG_YEAR:   r_year  = val[YRULE_W-1:0];
            default:    r_wmask = val[WMASK_W-1:0];
        endcase
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic load_rules(logic [RULE_W-1:0] mn, logic [RULE_W-1:0] hr,
                              logic [RULE_W-1:0] dy, logic [RULE_W-1:0] mo,
                              logic [YRULE_W-1:0] yr, logic [WMASK_W-1:0] wm);
        drain();
        write_reg(CFG_MINUTE, mn);
        write_reg(CFG_HOUR, hr);
        write_reg(CFG_DAY, dy);
        write_reg(CFG_MONTH, mo);
        write_reg(CFG_YEAR, yr);
        write_reg(CFG_WMASK, wm);
        cfg_we <= 1'b0;
    endtask

    task automatic send(req_t item, bit has_exp, rsp_t exp_val);
        if (!quiet)
            while ($urandom_range(99) < 7)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_q = {pending_q, (has_exp ? exp_val : next_match(item))};
    endtask

    function automatic req_t rand_start();
        req_t s;
        if ($urandom_range(99) < 8)
            s = req_t'($urandom);
        else
        begin
            s.start_year   = 12'($urandom_range(2042, 1968));
            s.start_month  = 4'($urandom_range(12, 1));
            s.start_day    = 5'($urandom_range(31, 1));
            s.start_hour   = 5'($urandom_range(23, 0));
            s.start_minute = 6'($urandom_range(59, 0));
        end
        return s;
    endfunction

    // result side: random stall, long hold on request, check each transfer
    always @(posedge clk)
    begin
        rsp_t e;
        if (rsp_valid && !rsp_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual %p", $time, rsp);
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (rsp.next_year !== e.next_year)
                    $display("%0t: next_year exp %0d act %0d", $time, e.next_year,
                             rsp.next_year);
                if (rsp.next_month !== e.next_month)
                    $display("%0t: next_month exp %0d act %0d", $time, e.next_month,
                             rsp.next_month);
                if (rsp.next_day !== e.next_day)
                    $display("%0t: next_day exp %0d act %0d", $time, e.next_day,
                             rsp.next_day);
                if (rsp.next_hour !== e.next_hour)
                    $display("%0t: next_hour exp %0d act %0d", $time, e.next_hour,
                             rsp.next_hour);
                if (rsp.next_minute !== e.next_minute)
                    $display("%0t: next_minute exp %0d act %0d", $time, e.next_minute,
                             rsp.next_minute);
                if (rsp.no_match !== e.no_match)
                    $display("%0t: no_match exp %0d act %0d", $time, e.no_match,
                             rsp.no_match);
                if (rsp !== e)
                    errors++;
            end
        end
        if (press_go)
        begin
            press_go = 0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= !quiet && ($urandom_range(99) < 7);
    end

    typedef struct {
        bit   permissive;
        req_t start;
        bit   has_exp;
        rsp_t exp_val;
    } row_t;

    localparam rsp_t MISS = '{default: '0, no_match: 1'b1};

    row_t plan[] = '{
        '{0, '{12'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1, MISS},
        '{0, '{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63}, 1, MISS},
        '{0, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0}, 1, MISS},
        '{0, '{12'd2039, 4'd12, 5'd31, 5'd23, 6'd59}, 1, MISS},
        '{1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0}, 1,
            '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd1, 1'b0}},
        '{1, '{12'd1800, 4'd6, 5'd15, 5'd12, 6'd30}, 1,
            '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 1'b0}},
        '{1, '{12'd2039, 4'd12, 5'd31, 5'd23, 6'd59}, 1, MISS},
        '{1, '{12'd2040, 4'd1, 5'd1, 5'd0, 6'd0}, 1, MISS},
        '{1, '{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63}, 1, MISS},
        '{1, '{12'd2024, 4'd2, 5'd28, 5'd23, 6'd59}, 0, MISS},
        '{1, '{12'd2023, 4'd2, 5'd28, 5'd23, 6'd59}, 0, MISS},
        '{1, '{12'd2000, 4'd2, 5'd29, 5'd23, 6'd59}, 0, MISS},
        '{1, '{12'd2001, 4'd4, 5'd30, 5'd23, 6'd59}, 0, MISS},
        '{1, '{12'd1999, 4'd12, 5'd31, 5'd23, 6'd59}, 0, MISS},
        '{1, '{12'd2010, 4'd0, 5'd0, 5'd0, 6'd0}, 0, MISS},
        '{1, '{12'd2010, 4'd13, 5'd5, 5'd5, 6'd5}, 0, MISS},
        '{1, '{12'd2010, 4'd6, 5'd31, 5'd30, 6'd62}, 0, MISS},
        '{1, '{12'd2010, 4'd6, 5'd10, 5'd24, 6'd0}, 0, MISS},
        '{1, '{12'd2010, 4'd6, 5'd10, 5'd10, 6'd63}, 0, MISS}
    };

    initial
    begin
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        req_t s;
        int   lo, hi;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        req_valid = 1'b0;
        req       = '0;
        rsp_stall = 1'b0;
        errors    = 0;
        quiet     = 0;
        press_go  = 0;
        hold_cnt  = 0;
        r_min     = MINUTE_RULE_RST;
        r_hour    = HOUR_RULE_RST;
        r_day     = DAY_RULE_RST;
        r_mon     = MONTH_RULE_RST;
        r_year    = YEAR_RULE_RST;
        r_wmask   = WMASK_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].permissive && (i == 0 || !plan[i-1].permissive))
                load_rules(pack6(0, 63, 0), pack6(0, 63, 0), pack6(0, 63, 0),
                           pack6(0, 63, 0), pack_year(0, 4095, 0), 7'h7f);
            send(plan[i].start, plan[i].has_exp, plan[i].exp_val);
        end

        // extremes: all-ones rules and all-zero rules, each a handful of searches
        load_rules('1, '1, '1, '1, '1, '1);
        repeat (4) send(rand_start(), 0, MISS);
        load_rules('0, '0, '0, '0, '0, '0);
        repeat (3) send(rand_start(), 0, MISS);

        for (int ph = 0; ph < 8; ph++)
        begin
            lo = $urandom_range(2035, 1965);
            hi = lo + $urandom_range(200, 3);
            load_rules(
                ($urandom_range(9) == 0) ? RULE_W'($urandom)
                    : pack6($urandom_range(40), $urandom_range(63, 45), $urandom_range(15)),
                pack6($urandom_range(10), $urandom_range(31, 12), $urandom_range(6)),
                pack6($urandom_range(10), $urandom_range(63, 20), $urandom_range(4)),
                pack6($urandom_range(5), $urandom_range(15, 6), $urandom_range(3)),
                pack_year(lo, hi, $urandom_range(3)),
                WMASK_W'($urandom_range(127, 1)));
            for (int k = 0; k < 72; k++)
            begin
                quiet = (ph == 3);
                if (ph == 5 && k == 10)
                    press_go = 1;
                send(rand_start(), 0, MISS);
            end
            quiet = 0;
        end

        req_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
